[design/ept_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eye pupil tracker package
// Shared widths, fixed-point constants, register indexes and the status
// struct returned by the CORDIC unit.
// ----------------------------------------------------------------------------
package ept_pkg;

  // Field widths
  localparam int MOUSE_W    = 12;
  localparam int PUPIL_W    = 10;
  localparam int SIZE_W     = 10;
  localparam int ORIGIN_W   = 12;
  localparam int ECNT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Internal datapath widths
  localparam int DIFF_W  = 14;  // mouse minus eye centre, signed
  localparam int VEC_W   = 34;  // CORDIC vector carrier
  localparam int ACC_W   = 20;  // cos/sin carrier during rotation
  localparam int UNIT_W  = 17;  // saturated Q1.15 cos/sin
  localparam int HR_W    = 8;   // half radius
  localparam int PROD_W  = 26;  // UNIT_W x (HR_W + 1) signed product
  localparam int OFF_W   = 12;  // pupil offset, signed
  localparam int COORD_W = 12;  // centre plus offset before wrap

  // Fixed-point constants
  localparam int UNITY_Q15       = 32768;
  localparam int CORDIC_INV_GAIN = 19898;
  localparam int VEC_SHIFT       = 16;
  localparam int Q_SHIFT         = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GADGET_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GADGET_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GADGET_SCREEN_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GADGET_SCREEN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_COUNT       = 3'd4;

  // Status of the CORDIC unit
  typedef struct packed {
    logic busy;
    logic done;
  } cord_rsp_t;

endpackage
`default_nettype wire

[design/eye_pupil_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eye pupil tracker core
// Lays out up to MAX_EYE_COUNT eyes in a gadget and, for each mouse word,
// gives one pupil position per eye with moved and redraw flags.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake       | Payload
//  --------+-----------+-----------------+-------------------------------------
//  in      | input     | in_valid/stall  | mouse_x, mouse_y
//  out     | output    | out_valid/stall | eye_index, pupil_x, pupil_y, moved,
//          |           |                 | last_eye, any_moved
//  cfg     | input     | cfg_we          | cfg_index, cfg_data
//
// A mouse word runs a serial divide for the half eye pitch, then per eye
// one pass of the shared CORDIC unit (one micro-rotation per cycle) and
// the S_MULX and S_MULY steps on the shared multiplier. in_stall is high
// from acceptance until the last result is loaded into the output
// register. Reset is synchronous; every pupil starts at its eye centre
// with no clearing pass. A stalled result holds the sequencer in its emit
// step.
// ----------------------------------------------------------------------------
module eye_pupil_tracker_core #(
  parameter int MAX_EYE_COUNT = 4,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [ept_pkg::MOUSE_W-1:0]           in_mouse_x,
  input  wire [ept_pkg::MOUSE_W-1:0]           in_mouse_y,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           out_eye_index,
  output logic [ept_pkg::PUPIL_W-1:0]          out_pupil_x,
  output logic [ept_pkg::PUPIL_W-1:0]          out_pupil_y,
  output logic                                 out_moved,
  output logic                                 out_last_eye,
  output logic                                 out_any_moved,
  input  wire                                  cfg_we,
  input  wire [ept_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [ept_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int EW  = (MAX_EYE_COUNT > 1) ? $clog2(MAX_EYE_COUNT) : 1;
  localparam int NW  = $clog2(MAX_EYE_COUNT + 1);
  localparam int DVW = $clog2(2 * MAX_EYE_COUNT + 1);
  localparam int SW  = ept_pkg::SIZE_W;
  localparam int PW  = ept_pkg::PUPIL_W;
  localparam int MW  = ept_pkg::MOUSE_W;
  localparam int HW  = ept_pkg::HR_W;
  localparam int QW  = ept_pkg::PROD_W;
  localparam int OW  = ept_pkg::OFF_W;
  localparam int CW  = ept_pkg::COORD_W;
  localparam int DW  = ept_pkg::DIFF_W;
  localparam int UW  = ept_pkg::UNIT_W;
  localparam int SUMW = DW - 1;
  localparam int Q_LO = ept_pkg::Q_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_GEOM, S_EYE, S_CORD, S_MULX, S_MULY, S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [SW-1:0]              width_r, width_nxt, height_r, height_nxt;
  logic [ept_pkg::ORIGIN_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [ept_pkg::ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [MW-1:0]              mx_r, mx_nxt, my_r, my_nxt;
  logic [DVW-1:0]             rem_r, rem_nxt;
  logic [SW-1:0]              quo_r, quo_nxt;
  logic [3:0]                 dcnt_r, dcnt_nxt;
  logic [SW:0]                cx_r, cx_nxt;
  logic [PW-1:0]              cy_r, cy_nxt;
  logic [HW-1:0]              hrx_r, hrx_nxt, hry_r, hry_nxt;
  logic [EW-1:0]              eye_r, eye_nxt;
  logic                       any_r, any_nxt;
  logic signed [QW-1:0]       prod_r, prod_nxt;
  logic [PW-1:0]              px_r, px_nxt;
  logic [MAX_EYE_COUNT-1:0]   fresh_r, fresh_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_eye_r, out_eye_nxt;
  logic [PW-1:0]              out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic                       out_mv_r, out_mv_nxt, out_last_r, out_last_nxt;
  logic                       out_any_r, out_any_nxt;

  logic [PW-1:0]              prev_x_r [MAX_EYE_COUNT];
  logic [PW-1:0]              prev_y_r [MAX_EYE_COUNT];

  // Combinational helpers
  logic [NW-1:0]              n_act;
  logic [DVW-1:0]             divisor;
  logic [DVW:0]               rem_sh;
  logic                       rem_ge;
  logic [SW-1:0]              dividend, ry_full;
  logic [SW-1:0]              rx;
  logic [SW-2:0]              ys;
  logic [SUMW-1:0]            sum_x, sum_y;
  logic signed [DW-1:0]       dx, dy;
  logic                       cord_start;
  ept_pkg::cord_rsp_t         cord_rsp;
  logic signed [UW-1:0]       cos_q, sin_q;
  logic signed [UW-1:0]       mul_a;
  logic [HW-1:0]              mul_b;
  logic signed [QW-1:0]       mul_p;
  logic [QW-1:0]              prod_mag;
  logic [QW-Q_LO-1:0]         off_mag;
  logic signed [OW-1:0]       off;
  logic signed [CW-1:0]       px_sum, py_sum;
  logic [PW-1:0]              py_w, cmp_x, cmp_y;
  logic                       moved, is_last, emit_go, cfg_hit;

  // Active eye count: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (ecnt_r == '0) begin
      n_act = NW'(1);
    end else if (32'(ecnt_r) > MAX_EYE_COUNT) begin
      n_act = NW'(MAX_EYE_COUNT);
    end else begin
      n_act = NW'(ecnt_r);
    end
  end

  // Restoring divider for the half eye pitch (W - 4) / (2n), one bit a cycle.
  assign dividend = (width_r >= SW'(4)) ? (width_r - SW'(4)) : '0;
  assign divisor  = DVW'({n_act, 1'b0});
  assign rem_sh   = {rem_r, quo_r[SW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});

  assign rx      = (quo_r == '0) ? '0 : (quo_r - SW'(1));
  assign ys      = (height_r >= SW'(4)) ? (SW-1)'((height_r - SW'(4)) >> 1) : '0;
  assign ry_full = (ys == '0) ? '0 : SW'(ys - (SW-1)'(1));

  // Mouse relative to the eye centre in screen coordinates.
  assign sum_x = SUMW'(sx_r) + SUMW'(cx_r);
  assign sum_y = SUMW'(sy_r) + SUMW'(cy_r);
  assign dx    = $signed(DW'(mx_r)) - $signed({1'b0, sum_x});
  assign dy    = $signed(DW'(my_r)) - $signed({1'b0, sum_y});

  assign cord_start = (state_r == S_EYE);

  ept_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .dx    (dx),
    .dy    (dy),
    .rsp   (cord_rsp),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // Shared multiplier: cos by the horizontal half radius, then sin by the
  // vertical one.
  assign mul_a = (state_r == S_MULX) ? cos_q : sin_q;
  assign mul_b = (state_r == S_MULX) ? hrx_r : hry_r;
  assign mul_p = QW'(mul_a) * QW'($signed({1'b0, mul_b}));

  // Scale back by 2^15 with truncation toward zero.
  assign prod_mag = prod_r[QW-1] ? QW'(-prod_r) : QW'(prod_r);
  assign off_mag  = prod_mag[QW-1:Q_LO];
  assign off      = prod_r[QW-1] ? -$signed(OW'(off_mag)) : $signed(OW'(off_mag));

  assign px_sum = $signed(CW'(cx_r)) + CW'(off);
  assign py_sum = $signed(CW'(cy_r)) + CW'(off);
  assign py_w   = py_sum[PW-1:0];

  // An entry not yet written since the last layout change reads as the centre.
  assign cmp_x   = fresh_r[eye_r] ? cx_r[PW-1:0] : prev_x_r[eye_r];
  assign cmp_y   = fresh_r[eye_r] ? cy_r : prev_y_r[eye_r];
  assign moved   = (px_r != cmp_x) || (py_w != cmp_y);
  assign is_last = ((NW'(eye_r) + NW'(1)) == n_act);
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign cfg_hit = cfg_we && (cfg_index <= ept_pkg::CFG_EYE_COUNT);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ecnt_nxt      = ecnt_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    hrx_nxt       = hrx_r;
    hry_nxt       = hry_r;
    eye_nxt       = eye_r;
    any_nxt       = any_r;
    prod_nxt      = prod_r;
    px_nxt        = px_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_eye_nxt   = out_eye_r;
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_mv_nxt    = out_mv_r;
    out_last_nxt  = out_last_r;
    out_any_nxt   = out_any_r;

    if (cfg_we) begin
      case (cfg_index)
        ept_pkg::CFG_GADGET_WIDTH:    width_nxt  = cfg_data[SW-1:0];
        ept_pkg::CFG_GADGET_HEIGHT:   height_nxt = cfg_data[SW-1:0];
        ept_pkg::CFG_GADGET_SCREEN_X: sx_nxt     = cfg_data;
        ept_pkg::CFG_GADGET_SCREEN_Y: sy_nxt     = cfg_data;
        ept_pkg::CFG_EYE_COUNT:       ecnt_nxt   = cfg_data[ept_pkg::ECNT_W-1:0];
        default: begin
        end
      endcase
    end
    if (cfg_hit) begin
      fresh_nxt = '1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mx_nxt    = in_mouse_x;
          my_nxt    = in_mouse_y;
          quo_nxt   = dividend;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          eye_nxt   = '0;
          any_nxt   = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_ge ? DVW'(rem_sh - {1'b0, divisor}) : DVW'(rem_sh);
        quo_nxt  = {quo_r[SW-2:0], rem_ge};
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(SW - 1)) begin
          state_nxt = S_GEOM;
        end
      end
      S_GEOM: begin
        hrx_nxt   = HW'(rx >> 1);
        hry_nxt   = HW'(ry_full >> 1);
        cx_nxt    = (SW+1)'(quo_r) + (SW+1)'(2);
        cy_nxt    = PW'(ys) + PW'(2);
        state_nxt = S_EYE;
      end
      S_EYE: begin
        state_nxt = S_CORD;
      end
      S_CORD: begin
        if (cord_rsp.done) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        prod_nxt  = mul_p;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        px_nxt    = px_sum[PW-1:0];
        prod_nxt  = mul_p;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt      = 1'b1;
          out_eye_nxt        = 2'(eye_r);
          out_px_nxt         = px_r;
          out_py_nxt         = py_w;
          out_mv_nxt         = moved;
          out_last_nxt       = is_last;
          out_any_nxt        = is_last && (any_r || moved);
          any_nxt            = any_r || moved;
          fresh_nxt[eye_r]   = 1'b0;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            eye_nxt   = eye_r + EW'(1);
            cx_nxt    = cx_r + {quo_r, 1'b0};
            state_nxt = S_EYE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= SW'(64);
      height_r    <= SW'(42);
      sx_r        <= '0;
      sy_r        <= '0;
      ecnt_r      <= ept_pkg::ECNT_W'(2);
      fresh_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      ecnt_r      <= ecnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dcnt_r     <= dcnt_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    hrx_r      <= hrx_nxt;
    hry_r      <= hry_nxt;
    eye_r      <= eye_nxt;
    any_r      <= any_nxt;
    prod_r     <= prod_nxt;
    px_r       <= px_nxt;
    out_eye_r  <= out_eye_nxt;
    out_px_r   <= out_px_nxt;
    out_py_r   <= out_py_nxt;
    out_mv_r   <= out_mv_nxt;
    out_last_r <= out_last_nxt;
    out_any_r  <= out_any_nxt;
  end

  // Previous pupil per eye.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      prev_x_r[eye_r] <= px_r;
      prev_y_r[eye_r] <= py_w;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_eye_index = out_eye_r;
  assign out_pupil_x   = out_px_r;
  assign out_pupil_y   = out_py_r;
  assign out_moved     = out_mv_r;
  assign out_last_eye  = out_last_r;
  assign out_any_moved = out_any_r;

  // The CORDIC unit only runs while the sequencer waits for it.
  a_cord_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (cord_rsp.busy || cord_rsp.done) |-> (state_r == S_CORD))
    else $error("CORDIC unit active outside its sequencer step");

  // The redraw flag only rides on the final word of a run.
  a_any_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_any_r) |-> out_last_r)
    else $error("any_moved set on a word that is not the last eye");

  // An accepted mouse word always starts the divide.
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV))
    else $error("accepted mouse word did not start the divide");

endmodule
`default_nettype wire

[design/ept_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eye pupil tracker CORDIC unit
// One micro-rotation per cycle: vectoring on (dx, dy) while the same
// directions rotate a unit vector, giving saturated Q1.15 cos and sin.
// ----------------------------------------------------------------------------
module ept_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire logic signed [ept_pkg::DIFF_W-1:0] dx,
  input  wire logic signed [ept_pkg::DIFF_W-1:0] dy,
  output ept_pkg::cord_rsp_t                    rsp,
  output logic signed [ept_pkg::UNIT_W-1:0]     cos_q,
  output logic signed [ept_pkg::UNIT_W-1:0]     sin_q
);

  localparam int KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int VW = ept_pkg::VEC_W;
  localparam int AW = ept_pkg::ACC_W;
  localparam int UW = ept_pkg::UNIT_W;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t               state_r, state_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic signed [VW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [AW-1:0]  c_r, c_nxt, s_r, s_nxt;
  logic                  flip_r, flip_nxt, zero_r, zero_nxt, done_r, done_nxt;
  logic signed [UW-1:0]  cos_r, cos_nxt, sin_r, sin_nxt;

  logic signed [VW-1:0]     x_sh, y_sh;
  logic signed [AW-1:0]     c_sh, s_sh, c_fin, s_fin, c_sat, s_sat;
  logic signed [ept_pkg::DIFF_W-1:0] adx, ady;

  assign x_sh = x_r >>> k_r;
  assign y_sh = y_r >>> k_r;
  assign c_sh = c_r >>> k_r;
  assign s_sh = s_r >>> k_r;

  // Fold the left half plane onto the right before vectoring.
  assign adx = dx[ept_pkg::DIFF_W-1] ? -dx : dx;
  assign ady = dx[ept_pkg::DIFF_W-1] ? -dy : dy;

  assign c_fin = flip_r ? -c_r : c_r;
  assign s_fin = flip_r ? -s_r : s_r;

  always_comb begin
    if (c_fin > ept_pkg::UNITY_Q15) begin
      c_sat = AW'(ept_pkg::UNITY_Q15);
    end else if (c_fin < -ept_pkg::UNITY_Q15) begin
      c_sat = AW'(-ept_pkg::UNITY_Q15);
    end else begin
      c_sat = c_fin;
    end
    if (s_fin > ept_pkg::UNITY_Q15) begin
      s_sat = AW'(ept_pkg::UNITY_Q15);
    end else if (s_fin < -ept_pkg::UNITY_Q15) begin
      s_sat = AW'(-ept_pkg::UNITY_Q15);
    end else begin
      s_sat = s_fin;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    c_nxt     = c_r;
    s_nxt     = s_r;
    flip_nxt  = flip_r;
    zero_nxt  = zero_r;
    done_nxt  = 1'b0;
    cos_nxt   = cos_r;
    sin_nxt   = sin_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          k_nxt    = '0;
          x_nxt    = VW'(adx) <<< ept_pkg::VEC_SHIFT;
          y_nxt    = VW'(ady) <<< ept_pkg::VEC_SHIFT;
          c_nxt    = AW'(ept_pkg::CORDIC_INV_GAIN);
          s_nxt    = '0;
          flip_nxt = dx[ept_pkg::DIFF_W-1];
          zero_nxt = (dx == '0) && (dy == '0);
          state_nxt = ((dx == '0) && (dy == '0)) ? C_FIN : C_RUN;
        end
      end
      C_RUN: begin
        if (!y_r[VW-1]) begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          c_nxt = c_r - s_sh;
          s_nxt = s_r + c_sh;
        end else begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          c_nxt = c_r + s_sh;
          s_nxt = s_r - c_sh;
        end
        k_nxt = k_r + KW'(1);
        if (32'(k_r) == CORDIC_STEPS - 1) begin
          state_nxt = C_FIN;
        end
      end
      C_FIN: begin
        cos_nxt   = zero_r ? UW'(ept_pkg::UNITY_Q15) : UW'(c_sat);
        sin_nxt   = zero_r ? '0 : UW'(s_sat);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    k_r    <= k_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    flip_r <= flip_nxt;
    zero_r <= zero_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign rsp      = ept_pkg::cord_rsp_t'{busy: (state_r != C_IDLE), done: done_r};
  assign cos_q    = cos_r;
  assign sin_q    = sin_r;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eye pupil tracker core testbench
// Drives mouse words through the core under a range of gadget layouts. A
// scoreboard class predicts every pupil result, including the CORDIC
// heading, and compares the results field by field as they leave the core.
// Both channels see random idle and stall bursts in most phases; the last
// phase runs without them.
module tb_top;
  import ept_pkg::*;

  localparam int EYE_SLOTS    = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_EYE_COUNT + 3'd1;

  typedef struct {
    logic [1:0]         eye_index;
    logic [PUPIL_W-1:0] pupil_x;
    logic [PUPIL_W-1:0] pupil_y;
    logic               moved;
    logic               last_eye;
    logic               any_moved;
  } pupil_rec_t;

  class pupil_scoreboard;
    int width, height, scr_x, scr_y, eyes;
    logic [PUPIL_W-1:0] last_px[EYE_SLOTS];
    logic [PUPIL_W-1:0] last_py[EYE_SLOTS];
    pupil_rec_t due[$];
    int errors;
    int checked;

    function new();
      width   = 64;
      height  = 42;
      scr_x   = 0;
      scr_y   = 0;
      eyes    = 2;
      errors  = 0;
      checked = 0;
      recentre();
    endfunction

    function int active_eyes();
      if (eyes < 1) return 1;
      if (eyes > EYE_SLOTS) return EYE_SLOTS;
      return eyes;
    endfunction

    function void geometry(input int i, output int cx, output int cy,
                           output int hx, output int hy);
      int n, xs, ys, rx, ry;
      n  = active_eyes();
      xs = ((width >= 4) ? width - 4 : 0) / (2 * n);
      ys = ((height >= 4) ? height - 4 : 0) / 2;
      rx = (xs > 0) ? xs - 1 : 0;
      ry = (ys > 0) ? ys - 1 : 0;
      cx = 2 + xs + 2 * xs * i;
      cy = 2 + ys;
      hx = rx / 2;
      hy = ry / 2;
    endfunction

    function void recentre();
      int i, cx, cy, hx, hy;
      for (i = 0; i < EYE_SLOTS; i++) begin
        geometry(i, cx, cy, hx, hy);
        last_px[i] = PUPIL_W'(cx);
        last_py[i] = PUPIL_W'(cy);
      end
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GADGET_WIDTH:    width  = data[SIZE_W-1:0];
        CFG_GADGET_HEIGHT:   height = data[SIZE_W-1:0];
        CFG_GADGET_SCREEN_X: scr_x  = data[ORIGIN_W-1:0];
        CFG_GADGET_SCREEN_Y: scr_y  = data[ORIGIN_W-1:0];
        CFG_EYE_COUNT:       eyes   = data[ECNT_W-1:0];
        default: return;
      endcase
      // Any accepted write lays the eyes out afresh.
      recentre();
    endfunction

    // Vectoring pass gives the rotation directions; the same directions
    // turn a gain-compensated unit vector into cos and sin.
    function void heading(input int dx0, input int dy0,
                          output longint cs, output longint sn);
      longint x, y, c, s, nx, nc;
      int dx, dy, k;
      bit flip;
      dx = dx0;
      dy = dy0;
      flip = 1'b0;
      if (dx == 0 && dy == 0) begin
        cs = UNITY_Q15;
        sn = 0;
        return;
      end
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
        flip = 1'b1;
      end
      x = longint'(dx) * (longint'(1) << VEC_SHIFT);
      y = longint'(dy) * (longint'(1) << VEC_SHIFT);
      c = CORDIC_INV_GAIN;
      s = 0;
      for (k = 0; k < CORDIC_STEPS; k++) begin
        if (y >= 0) begin
          nx = x + (y >>> k);
          y  = y - (x >>> k);
          nc = c - (s >>> k);
          s  = s + (c >>> k);
        end else begin
          nx = x - (y >>> k);
          y  = y + (x >>> k);
          nc = c + (s >>> k);
          s  = s - (c >>> k);
        end
        x = nx;
        c = nc;
      end
      if (flip) begin
        c = -c;
        s = -s;
      end
      if (c > UNITY_Q15) c = UNITY_Q15;
      if (c < -UNITY_Q15) c = -UNITY_Q15;
      if (s > UNITY_Q15) s = UNITY_Q15;
      if (s < -UNITY_Q15) s = -UNITY_Q15;
      cs = c;
      sn = s;
    endfunction

    // Product scaled back by 2^15, truncated toward zero.
    function int offset_of(input longint unit, input int half_r);
      longint p;
      p = unit * half_r;
      if (p < 0) return -int'((-p) >>> Q_SHIFT);
      return int'(p >>> Q_SHIFT);
    endfunction

    function void note_mouse(input logic [MOUSE_W-1:0] mx, input logic [MOUSE_W-1:0] my);
      int n, i, cx, cy, hx, hy;
      longint c, s;
      logic any;
      pupil_rec_t r;
      n = active_eyes();
      any = 1'b0;
      for (i = 0; i < n; i++) begin
        geometry(i, cx, cy, hx, hy);
        heading(int'(mx) - (scr_x + cx), int'(my) - (scr_y + cy), c, s);
        r.eye_index = 2'(i);
        r.pupil_x   = PUPIL_W'(cx + offset_of(c, hx));
        r.pupil_y   = PUPIL_W'(cy + offset_of(s, hy));
        r.moved     = (r.pupil_x != last_px[i]) || (r.pupil_y != last_py[i]);
        any         = any | r.moved;
        r.last_eye  = (i + 1 == n);
        r.any_moved = r.last_eye ? any : 1'b0;
        last_px[i]  = r.pupil_x;
        last_py[i]  = r.pupil_y;
        due.push_back(r);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void compare_field(input string name, input logic [PUPIL_W-1:0] want,
                                input logic [PUPIL_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $error("%s: expected %0d, actual %0d", name, want, seen);
      end
    endfunction

    function void check_pupil(input pupil_rec_t got);
      pupil_rec_t want;
      if (due.size() == 0) begin
        errors++;
        $error("pupil result for eye %0d arrived with no mouse word pending",
               got.eye_index);
        return;
      end
      want = due.pop_front();
      checked++;
      compare_field("eye_index", PUPIL_W'(want.eye_index), PUPIL_W'(got.eye_index));
      compare_field("pupil_x", want.pupil_x, got.pupil_x);
      compare_field("pupil_y", want.pupil_y, got.pupil_y);
      compare_field("moved", PUPIL_W'(want.moved), PUPIL_W'(got.moved));
      compare_field("last_eye", PUPIL_W'(want.last_eye), PUPIL_W'(got.last_eye));
      compare_field("any_moved", PUPIL_W'(want.any_moved), PUPIL_W'(got.any_moved));
    endfunction

    function void flush_check();
      if (due.size() != 0) begin
        errors += due.size();
        $error("%0d expected pupil results never arrived", due.size());
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [MOUSE_W-1:0]    in_mouse_x    = '0;
  logic [MOUSE_W-1:0]    in_mouse_y    = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [1:0]            out_eye_index;
  logic [PUPIL_W-1:0]    out_pupil_x;
  logic [PUPIL_W-1:0]    out_pupil_y;
  logic                  out_moved;
  logic                  out_last_eye;
  logic                  out_any_moved;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  pupil_scoreboard sb = new();
  int idle_pct    = 30;
  int stall_left  = 0;
  int cycle_count = 0;
  int words_sent  = 0;
  int layouts     = 0;
  logic [MOUSE_W-1:0] last_mx = '0;
  logic [MOUSE_W-1:0] last_my = '0;

  eye_pupil_tracker_core #(
    .MAX_EYE_COUNT(EYE_SLOTS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mouse_x   (in_mouse_x),
    .in_mouse_y   (in_mouse_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_eye_index(out_eye_index),
    .out_pupil_x  (out_pupil_x),
    .out_pupil_y  (out_pupil_y),
    .out_moved    (out_moved),
    .out_last_eye (out_last_eye),
    .out_any_moved(out_any_moved),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n || idle_pct == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct / 3) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    pupil_rec_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.eye_index = out_eye_index;
      got.pupil_x   = out_pupil_x;
      got.pupil_y   = out_pupil_y;
      got.moved     = out_moved;
      got.last_eye  = out_last_eye;
      got.any_moved = out_any_moved;
      sb.check_pupil(got);
    end
  end

  // Sampling at the falling edge keeps the exit independent of the monitor.
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_layout(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                              input logic [CFG_DATA_W-1:0] n, input bit spare);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(CFG_GADGET_WIDTH, w);
    write_reg(CFG_GADGET_HEIGHT, h);
    write_reg(CFG_GADGET_SCREEN_X, sx);
    write_reg(CFG_GADGET_SCREEN_Y, sy);
    write_reg(CFG_EYE_COUNT, n);
    // Indexes past the register list must leave the layout alone.
    if (spare)
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    layouts++;
  endtask

  task automatic send_mouse(input logic [MOUSE_W-1:0] mx, input logic [MOUSE_W-1:0] my);
    in_valid   <= 1'b1;
    in_mouse_x <= mx;
    in_mouse_y <= my;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_mouse(mx, my);
    words_sent++;
    last_mx = mx;
    last_my = my;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      // Now and then let the core run dry so the gap lands on an idle core.
      if ($urandom_range(0, 2) == 0) wait_drained();
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [MOUSE_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > (1 << MOUSE_W) - 1) return '1;
    return MOUSE_W'(v);
  endfunction

  task automatic random_mouse(output logic [MOUSE_W-1:0] mx, output logic [MOUSE_W-1:0] my);
    int sel, j, cx, cy, hx, hy;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      mx = MOUSE_W'($urandom);
      my = MOUSE_W'($urandom);
    end else if (sel < 25) begin
      mx = last_mx;
      my = last_my;
    end else if (sel < 35) begin
      j = $urandom_range(0, sb.active_eyes() - 1);
      sb.geometry(j, cx, cy, hx, hy);
      mx = clamp_coord(sb.scr_x + cx);
      my = clamp_coord(sb.scr_y + cy);
    end else begin
      mx = clamp_coord(sb.scr_x + int'($urandom_range(0, sb.width + 64)) - 32);
      my = clamp_coord(sb.scr_y + int'($urandom_range(0, sb.height + 64)) - 32);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    logic [SIZE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) v = SIZE_W'($urandom_range(0, 7));
    else if (r < 30) v = SIZE_W'($urandom_range(900, 1023));
    else v = SIZE_W'($urandom_range(8, 300));
    return {2'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_origin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CFG_DATA_W'($urandom_range(0, 400));
    if (r < 75) return CFG_DATA_W'($urandom_range(3500, 4095));
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_eye_count();
    logic [ECNT_W-1:0] n;
    if ($urandom_range(0, 99) < 80) n = ECNT_W'($urandom_range(1, EYE_SLOTS));
    else n = ECNT_W'($urandom_range(0, 7));
    return {9'($urandom), n};
  endfunction

  initial begin : stimulus
    logic [MOUSE_W-1:0] mx, my;
    int ph, k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout: two eyes with centres at (17,21) and (47,21).
    send_mouse(12'd17, 12'd21);
    send_mouse(12'd17, 12'd21);
    send_mouse(12'd47, 12'd21);
    send_mouse(12'd0, 12'd0);
    send_mouse(12'd4095, 12'd4095);
    send_mouse(12'd4095, 12'd0);
    send_mouse(12'd0, 12'd4095);
    send_mouse(12'd17, 12'd0);
    send_mouse(12'd17, 12'd4095);
    send_mouse(12'd0, 12'd21);
    send_mouse(12'hAAA, 12'h555);
    send_mouse(12'h555, 12'hAAA);

    // Empty gadget: sizes saturate, radii clamp and a zero eye count acts as one.
    apply_layout(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
    send_mouse(12'd2, 12'd2);
    send_mouse(12'd4095, 12'd4095);

    // Eye count above the maximum, origin at the far screen corner.
    apply_layout(12'd3, 12'd1023, 12'd4095, 12'd4095, 12'd7, 1'b0);
    send_mouse(12'd4095, 12'd4095);
    send_mouse(12'd0, 12'd0);

    // One wide, flat eye.
    apply_layout(12'd1023, 12'd8, 12'd0, 12'd0, 12'd1, 1'b1);
    send_mouse(12'd511, 12'd4);
    send_mouse(12'd1023, 12'd4);
    send_mouse(12'd0, 12'd4095);
    send_mouse(12'd511, 12'd0);

    // Full-size gadget with four eyes.
    apply_layout(12'd1023, 12'd1023, 12'd0, 12'd0, 12'd4, 1'b0);
    send_mouse(12'd4095, 12'd511);
    send_mouse(12'd129, 12'd511);
    send_mouse(12'd383, 12'd0);

    for (ph = 0; ph < 8; ph++) begin
      apply_layout(pick_size(), pick_size(), pick_origin(), pick_origin(),
                   pick_eye_count(), $urandom_range(0, 1));
      if (ph == 7) idle_pct <= 0;
      else idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      for (k = 0; k < 40; k++) begin
        random_mouse(mx, my);
        send_mouse(mx, my);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    sb.flush_check();
    $display("Sent %0d mouse words over %0d layouts and checked %0d pupil results.",
             words_sent, layouts + 1, sb.checked);
    $display("Layouts ranged from an empty gadget to full size, eye counts 0 to 7.");
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[eye_pupil_tracker_core.f]
design/ept_pkg.sv
design/ept_cordic.sv
design/eye_pupil_tracker_core.sv
tb/tb_top.sv
